/* rtl/ptpc_pkg.sv */
// ----------------------------------------------------------------------------
// ptpc_pkg: shared types and constants of the PTP packet classifier
// Frame field codes, position constants, verdict codes and the item and
// result structs that travel between the classifier stages.
// ----------------------------------------------------------------------------
`default_nettype none

package ptpc_pkg;

  // Byte position width; positions saturate at the all-ones value
  localparam int PosW = 7;
  localparam logic [PosW-1:0] POS_MAX = {PosW{1'b1}};

  // Ethertypes and protocol fields
  localparam logic [15:0] ETYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETYPE_PTP  = 16'h88f7;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86dd;
  localparam logic [7:0]  PROTO_UDP  = 8'h11;
  localparam logic [15:0] PORT_EVENT   = 16'd319;
  localparam logic [15:0] PORT_GENERAL = 16'd320;
  localparam logic [12:0] FRAG_OFS_MASK = 13'h1FFF;
  localparam int          FRAG_MF_BIT   = 13;

  // Header positions and lengths
  localparam logic [PosW-1:0] L3_BASE          = 7'd14;
  localparam logic [PosW-1:0] VLAN_TAG_BYTES   = 7'd4;
  localparam logic [PosW-1:0] TYPE_POS0        = 7'd13;
  localparam logic [PosW-1:0] TYPE_POS1        = 7'd17;
  localparam logic [PosW-1:0] TYPE_POS2        = 7'd21;
  localparam logic [PosW-1:0] L3_AFTER1        = 7'd18;
  localparam logic [PosW-1:0] L3_AFTER2        = 7'd22;
  localparam logic [PosW-1:0] IPV4_FRAG_LO     = 7'd7;
  localparam logic [PosW-1:0] IPV4_PROTO       = 7'd9;
  localparam logic [PosW-1:0] IPV6_NEXT        = 7'd6;
  localparam logic [PosW-1:0] IPV6_FIXED_BYTES = 7'd40;
  localparam logic [PosW-1:0] UDP_DPORT_LO     = 7'd3;
  localparam logic [PosW-1:0] UDP_HEADER_BYTES = 7'd8;
  localparam logic [PosW:0]   PTP_LAST_OFS     = 8'd33;
  localparam logic [3:0]      IHL_MIN          = 4'd5;

  // Layer-3 kind codes
  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_L2PTP   = 2'd1;
  localparam logic [1:0] KIND_IPV4    = 2'd2;
  localparam logic [1:0] KIND_IPV6    = 2'd3;

  // Verdict codes
  localparam logic [1:0] VERDICT_EVENT   = 2'd0;
  localparam logic [1:0] VERDICT_GENERAL = 2'd1;
  localparam logic [1:0] VERDICT_INVALID = 2'd2;
  localparam logic [1:0] VERDICT_NOT_PTP = 2'd3;

  // Message type ranges
  localparam logic [3:0] MT_EVENT_MAX   = 4'd3;
  localparam logic [3:0] MT_GENERAL_MIN = 4'd8;
  localparam logic [3:0] MT_GENERAL_MAX = 4'd13;

  // One registered input byte
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       eof;
  } item_t;

  // One classification result
  typedef struct packed {
    logic [1:0]      verdict;
    logic [PosW-1:0] offset;
    logic [3:0]      mtype;
  } result_t;

endpackage

`default_nettype wire

/* rtl/ptpc_in_stage.sv */
// ----------------------------------------------------------------------------
// ptpc_in_stage: input register of the classifier
// Holds one frame byte; refills in the same cycle the held byte moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module ptpc_in_stage
  import ptpc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       frame_valid,
  output logic            frame_ready,
  input  wire logic [7:0] frame_byte,
  input  wire logic       end_of_frame,
  input  wire logic       advance,
  output item_t           item
);

  logic       valid;
  logic [7:0] data;
  logic       eof;

  // Space when empty or when the held byte leaves this cycle
  assign frame_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (frame_valid && frame_ready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      data <= frame_byte;
      eof  <= end_of_frame;
    end
  end

  assign item = '{valid: valid, data: data, eof: eof};

endmodule

`default_nettype wire

/* rtl/ptpc_parse.sv */
// ----------------------------------------------------------------------------
// ptpc_parse: per-byte header parser of the classifier
// Tracks the byte position and header layout of the current frame and forms
// the verdict combinationally on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ptpc_parse
  import ptpc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire item_t item,
  input  wire logic  advance,
  output result_t    result
);

  logic [PosW-1:0] pos;
  logic [7:0]      prev_byte;
  logic [PosW-1:0] l3_start;
  logic [1:0]      l3_kind;
  logic [PosW-1:0] l4_start;
  logic [PosW-1:0] ptp_start;
  logic [3:0]      captured_type;
  logic            rejected;
  logic            type_seen;

  logic [PosW-1:0] l3_start_next;
  logic [1:0]      l3_kind_next;
  logic [PosW-1:0] l4_start_next;
  logic [PosW-1:0] ptp_start_next;
  logic [3:0]      captured_type_next;
  logic            rejected_next;
  logic            type_seen_next;

  logic [15:0]     word;
  logic [3:0]      ihl;
  logic            type_pos;
  logic            ptp_ok;
  logic [PosW:0]   ptp_last;

  assign word = {prev_byte, item.data};
  assign ihl  = item.data[3:0];
  assign type_pos = (pos == TYPE_POS0) ||
                    (pos == TYPE_POS1 && l3_start == L3_AFTER1) ||
                    (pos == TYPE_POS2 && l3_start == L3_AFTER2);

  // Header walk for the current byte
  always_comb begin
    l3_start_next      = l3_start;
    l3_kind_next       = l3_kind;
    l4_start_next      = l4_start;
    ptp_start_next     = ptp_start;
    captured_type_next = captured_type;
    rejected_next      = rejected;
    type_seen_next     = type_seen;
    if (!rejected) begin
      case (l3_kind)
        KIND_UNKNOWN: begin
          if (type_pos) begin
            if (pos < TYPE_POS2 && word == ETYPE_VLAN) begin
              l3_start_next = l3_start + VLAN_TAG_BYTES;
            end else if (word == ETYPE_PTP) begin
              l3_kind_next   = KIND_L2PTP;
              ptp_start_next = l3_start;
            end else if (word == ETYPE_IPV4) begin
              l3_kind_next = KIND_IPV4;
            end else if (word == ETYPE_IPV6) begin
              l3_kind_next = KIND_IPV6;
            end else begin
              rejected_next = 1'b1;
            end
          end
        end
        KIND_IPV4: begin
          if (pos == l3_start) begin
            if (ihl < IHL_MIN) begin
              rejected_next = 1'b1;
            end else begin
              l4_start_next = l3_start + {1'b0, ihl, 2'b00};
            end
          end
          // MF set or nonzero fragment offset
          if (pos == l3_start + IPV4_FRAG_LO) begin
            if (word[FRAG_MF_BIT] || (word[12:0] & FRAG_OFS_MASK) != 13'd0) begin
              rejected_next = 1'b1;
            end
          end
          if (pos == l3_start + IPV4_PROTO && item.data != PROTO_UDP) begin
            rejected_next = 1'b1;
          end
        end
        KIND_IPV6: begin
          // Fragment header and every other non-UDP next header reject
          if (pos == l3_start + IPV6_NEXT) begin
            if (item.data != PROTO_UDP) begin
              rejected_next = 1'b1;
            end else begin
              l4_start_next = l3_start + IPV6_FIXED_BYTES;
            end
          end
        end
        default: begin
        end
      endcase
      // UDP destination port check
      if ((l3_kind == KIND_IPV4 || l3_kind == KIND_IPV6) && !rejected_next &&
          l4_start_next != '0 && pos == l4_start_next + UDP_DPORT_LO) begin
        if (word == PORT_EVENT || word == PORT_GENERAL) begin
          ptp_start_next = l4_start_next + UDP_HEADER_BYTES;
        end else begin
          rejected_next = 1'b1;
        end
      end
      // First PTP header byte carries the message type
      if (!rejected_next && ptp_start_next != '0 && pos == ptp_start_next) begin
        captured_type_next = item.data[3:0];
        type_seen_next     = 1'b1;
      end
    end
  end

  // Verdict on the final byte; the whole header must be in the frame
  assign ptp_last = {1'b0, ptp_start_next} + PTP_LAST_OFS;
  assign ptp_ok   = !rejected_next && ptp_start_next != '0 && type_seen_next &&
                    {1'b0, pos} >= ptp_last;

  always_comb begin
    result = '{verdict: VERDICT_NOT_PTP, offset: '0, mtype: 4'd0};
    if (ptp_ok) begin
      result.offset = ptp_start_next;
      result.mtype  = captured_type_next;
      if (captured_type_next <= MT_EVENT_MAX) begin
        result.verdict = VERDICT_EVENT;
      end else if (captured_type_next >= MT_GENERAL_MIN &&
                   captured_type_next <= MT_GENERAL_MAX) begin
        result.verdict = VERDICT_GENERAL;
      end else begin
        result.verdict = VERDICT_INVALID;
      end
    end
  end

  // Frame state: cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst || (advance && item.eof)) begin
      pos           <= '0;
      prev_byte     <= 8'd0;
      l3_start      <= L3_BASE;
      l3_kind       <= KIND_UNKNOWN;
      l4_start      <= '0;
      ptp_start     <= '0;
      captured_type <= 4'd0;
      rejected      <= 1'b0;
      type_seen     <= 1'b0;
    end else if (advance) begin
      if (pos != POS_MAX) begin
        pos <= pos + 7'd1;
      end
      prev_byte     <= item.data;
      l3_start      <= l3_start_next;
      l3_kind       <= l3_kind_next;
      l4_start      <= l4_start_next;
      ptp_start     <= ptp_start_next;
      captured_type <= captured_type_next;
      rejected      <= rejected_next;
      type_seen     <= type_seen_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/ptpc_out_stage.sv */
// ----------------------------------------------------------------------------
// ptpc_out_stage: result register of the classifier
// Holds one verdict until the downstream side takes the transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ptpc_out_stage
  import ptpc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t result,
  output logic         result_valid,
  input  wire logic    result_ready,
  output logic [1:0]   verdict,
  output logic [6:0]   header_offset,
  output logic [3:0]   message_type
);

  result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign verdict       = held.verdict;
  assign header_offset = held.offset;
  assign message_type  = held.mtype;

endmodule

`default_nettype wire

/* rtl/ptp_packet_classifier_unit.sv */
// ----------------------------------------------------------------------------
// ptp_packet_classifier_unit: IEEE 1588 frame classifier
// Byte-serial Ethernet parser that flags PTP event and general messages.
// ----------------------------------------------------------------------------
// Feed a frame one byte per transaction from the first destination MAC byte,
// marking the last byte with end_of_frame; the block takes a byte every cycle
// and presents one verdict per frame from the result register, loaded when the
// last byte moves on from the input register. The rate is set by the per-byte
// header walk, one short step between the input register and the result
// register; only a last byte waits, while the previous verdict is still held.
// Up to two VLAN tags are skipped; layer-2 PTP and UDP ports 319/320 over
// unfragmented IPv4 or over IPv6 with UDP as next header are recognized. A
// frame too short for the 34-byte PTP header reports not PTP with zero offset
// and type.
`default_nettype none

module ptp_packet_classifier_unit
  import ptpc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       frame_valid,
  output logic            frame_ready,
  input  wire logic [7:0] frame_byte,
  input  wire logic       end_of_frame,
  output logic            result_valid,
  input  wire logic       result_ready,
  output logic [1:0]      verdict,
  output logic [6:0]      header_offset,
  output logic [3:0]      message_type
);

  item_t   item;
  result_t result;
  logic    advance;

  // A byte moves on unless it is a last byte and the result slot is full
  assign advance = item.valid && (!item.eof || !result_valid || result_ready);

  ptpc_in_stage u_in_stage (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame_byte   (frame_byte),
    .end_of_frame (end_of_frame),
    .advance      (advance),
    .item         (item)
  );

  ptpc_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .advance (advance),
    .result  (result)
  );

  ptpc_out_stage u_out_stage (
    .clk           (clk),
    .rst           (rst),
    .load          (advance && item.eof),
    .result        (result),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .verdict       (verdict),
    .header_offset (header_offset),
    .message_type  (message_type)
  );

endmodule

`default_nettype wire
